// ----- rtl/obbsp_pkg.sv -----
// ----------------------------------------------------------------------------
// obbsp_pkg
// Types and fixed widths shared by the box support point block.
// ----------------------------------------------------------------------------
package obbsp_pkg;

    // Matrix entry, Q.16 after rounding from the Q.28 quaternion products
    localparam int M_W = 23;
    // Enlarged half-extent, unsigned, half_ext + 1
    localparam int E_W = 31;
    // Matrix entry times half-extent
    localparam int P_W = M_W + E_W + 1;
    // Sum of three signed products
    localparam int S_W = P_W + 3;
    // Rotated corner component, signed Q26.16 at full width
    localparam int R_W = S_W - 16;
    // Upper part of a rotated component
    localparam int H_W = R_W - 16;
    // Products with the direction
    localparam int HP_W = H_W + 32;
    localparam int LP_W = 17 + 32;
    // Exact dot product
    localparam int D_W = HP_W + 2 + 16;

    localparam int NUM_CORNERS = 8;

    // Corner signs by index, bit set means the positive half-extent
    localparam logic [NUM_CORNERS-1:0] SGN_X = 8'b0011_0011;
    localparam logic [NUM_CORNERS-1:0] SGN_Y = 8'b0110_0110;
    localparam logic [NUM_CORNERS-1:0] SGN_Z = 8'b1111_0000;

    // Register indexes
    localparam logic [2:0] REG_QUAT_W = 3'd0;
    localparam logic [2:0] REG_QUAT_X = 3'd1;
    localparam logic [2:0] REG_QUAT_Y = 3'd2;
    localparam logic [2:0] REG_QUAT_Z = 3'd3;
    localparam logic [2:0] REG_HALF_X = 3'd4;
    localparam logic [2:0] REG_HALF_Y = 3'd5;
    localparam logic [2:0] REG_HALF_Z = 3'd6;

    typedef struct packed {
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [31:0] centre_x;
        logic signed [31:0] centre_y;
        logic signed [31:0] centre_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [2:0]         corner_index;
    } out_t;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } quat_t;

endpackage

// ----- rtl/obb_support_point.sv -----
// ----------------------------------------------------------------------------
// obb_support_point
// Support point of an oriented box for GJK queries.
// ----------------------------------------------------------------------------
// Input channel (in_valid, in_ready, in_data) carries one query item: search
// direction and box centre. Output channel (out_valid, out_ready, out_data)
// returns one item per query: the farthest box corner plus the centre,
// saturated, and the corner index (lowest index on ties).
// The APB port holds the quaternion and the half-extents; write it only while
// no item is in flight. The matrix follows a write in the next cycle.
// Throughput: one item per cycle while the receiver takes items. The nine
// stages are: input, corner products, rotated corners, direction products,
// dot sums, three compare levels and the centre add with saturation.
// Each stage has its own valid bit and loads when it is empty or the next
// stage moves, so bubbles close up. When the receiver stalls, the output
// holds and the stages behind it fill; in_ready drops only once every stage
// holds an item.
// Reset clears all valid bits and loads the identity quaternion and
// half-extents of 0.5.
// ----------------------------------------------------------------------------
module obb_support_point (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  obbsp_pkg::in_t      in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output obbsp_pkg::out_t     out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int NS = 9;
    localparam int M_W = obbsp_pkg::M_W;
    localparam int E_W = obbsp_pkg::E_W;
    localparam int P_W = obbsp_pkg::P_W;
    localparam int S_W = obbsp_pkg::S_W;
    localparam int R_W = obbsp_pkg::R_W;
    localparam int H_W = obbsp_pkg::H_W;
    localparam int HP_W = obbsp_pkg::HP_W;
    localparam int LP_W = obbsp_pkg::LP_W;
    localparam int D_W = obbsp_pkg::D_W;
    localparam int NC = obbsp_pkg::NUM_CORNERS;

    // ---------------- configuration ----------------
    obbsp_pkg::quat_t quat_reg;
    logic [29:0] half_reg [3];
    logic        wr_en;
    logic [2:0]  wr_idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_reg.w  <= 16'sd16384;
            quat_reg.x  <= '0;
            quat_reg.y  <= '0;
            quat_reg.z  <= '0;
            half_reg[0] <= 30'd32768;
            half_reg[1] <= 30'd32768;
            half_reg[2] <= 30'd32768;
        end
        else if (wr_en)
        begin
            case (wr_idx)
                obbsp_pkg::REG_QUAT_W: quat_reg.w  <= pwdata[15:0];
                obbsp_pkg::REG_QUAT_X: quat_reg.x  <= pwdata[15:0];
                obbsp_pkg::REG_QUAT_Y: quat_reg.y  <= pwdata[15:0];
                obbsp_pkg::REG_QUAT_Z: quat_reg.z  <= pwdata[15:0];
                obbsp_pkg::REG_HALF_X: half_reg[0] <= pwdata[29:0];
                obbsp_pkg::REG_HALF_Y: half_reg[1] <= pwdata[29:0];
                obbsp_pkg::REG_HALF_Z: half_reg[2] <= pwdata[29:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (wr_idx)
            obbsp_pkg::REG_QUAT_W: prdata = 32'($signed(quat_reg.w));
            obbsp_pkg::REG_QUAT_X: prdata = 32'($signed(quat_reg.x));
            obbsp_pkg::REG_QUAT_Y: prdata = 32'($signed(quat_reg.y));
            obbsp_pkg::REG_QUAT_Z: prdata = 32'($signed(quat_reg.z));
            obbsp_pkg::REG_HALF_X: prdata = {2'b00, half_reg[0]};
            obbsp_pkg::REG_HALF_Y: prdata = {2'b00, half_reg[1]};
            obbsp_pkg::REG_HALF_Z: prdata = {2'b00, half_reg[2]};
            default:               prdata = '0;
        endcase
    end

    logic signed [M_W-1:0] mat [9];

    obbsp_matrix u_matrix (
        .clk  (clk),
        .quat (quat_reg),
        .mat  (mat)
    );

    // ---------------- stage control ----------------
    logic [NS:1] v_reg;
    logic [NS:1] en;

    always_comb
    begin
        en[NS] = !v_reg[NS] || out_ready;
        for (int s = NS - 1; s >= 1; s--)
        begin
            en[s] = !v_reg[s] || en[s+1];
        end
    end

    assign in_ready  = en[1];
    assign out_valid = v_reg[NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                v_reg[1] <= in_valid;
            end
            for (int s = 2; s <= NS; s++)
            begin
                if (en[s])
                begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

    // ---------------- stage 1: input ----------------
    logic signed [31:0] d1_reg [3];
    logic signed [31:0] c1_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            d1_reg[0] <= in_data.dir_x;
            d1_reg[1] <= in_data.dir_y;
            d1_reg[2] <= in_data.dir_z;
            c1_reg[0] <= in_data.centre_x;
            c1_reg[1] <= in_data.centre_y;
            c1_reg[2] <= in_data.centre_z;
        end
    end

    // ---------------- stage 2: matrix times half-extent ----------------
    logic signed [P_W-1:0] p_next [9];
    logic signed [P_W-1:0] p2_reg [9];
    logic signed [31:0]    d2_reg [3];
    logic signed [31:0]    c2_reg [3];
    logic signed [E_W:0]   ext [3];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            ext[j] = $signed({1'b0, E_W'(half_reg[j]) + E_W'(1)});
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                p_next[3*i+j] = P_W'(mat[3*i+j] * ext[j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            p2_reg <= p_next;
            d2_reg <= d1_reg;
            c2_reg <= c1_reg;
        end
    end

    // ---------------- stage 3: rotated corners ----------------
    logic signed [R_W-1:0] r_next [NC][3];
    logic signed [R_W-1:0] r3_reg [NC][3];
    logic signed [31:0]    d3_reg [3];
    logic signed [31:0]    c3_reg [3];
    logic signed [S_W-1:0] rsum [NC][3];
    logic [2:0]            sg [NC];

    always_comb
    begin
        for (int k = 0; k < NC; k++)
        begin
            sg[k] = {obbsp_pkg::SGN_Z[k], obbsp_pkg::SGN_Y[k], obbsp_pkg::SGN_X[k]};
            for (int i = 0; i < 3; i++)
            begin
                rsum[k][i] = S_W'(64'sd1 <<< 15);
                for (int j = 0; j < 3; j++)
                begin
                    if (sg[k][j])
                    begin
                        rsum[k][i] = rsum[k][i] + S_W'(p2_reg[3*i+j]);
                    end
                    else
                    begin
                        rsum[k][i] = rsum[k][i] - S_W'(p2_reg[3*i+j]);
                    end
                end
                r_next[k][i] = R_W'(rsum[k][i] >>> 16);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            r3_reg <= r_next;
            d3_reg <= d2_reg;
            c3_reg <= c2_reg;
        end
    end

    // ---------------- stage 4: products with the direction ----------------
    logic signed [HP_W-1:0] hp_next [NC][3];
    logic signed [LP_W-1:0] lp_next [NC][3];
    logic signed [HP_W-1:0] hp4_reg [NC][3];
    logic signed [LP_W-1:0] lp4_reg [NC][3];
    logic signed [R_W-1:0]  r4_reg [NC][3];
    logic signed [31:0]     c4_reg [3];
    logic signed [H_W-1:0]  hi [NC][3];
    logic signed [16:0]     lo [NC][3];

    always_comb
    begin
        for (int k = 0; k < NC; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                hi[k][i] = H_W'(r3_reg[k][i] >>> 16);
                lo[k][i] = $signed({1'b0, r3_reg[k][i][15:0]});
                hp_next[k][i] = HP_W'(hi[k][i] * d3_reg[i]);
                lp_next[k][i] = LP_W'(lo[k][i] * d3_reg[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            hp4_reg <= hp_next;
            lp4_reg <= lp_next;
            r4_reg  <= r3_reg;
            c4_reg  <= c3_reg;
        end
    end

    // ---------------- stage 5: exact dot products ----------------
    logic signed [D_W-1:0] dot_next [NC];
    logic signed [D_W-1:0] dot5_reg [NC];
    logic signed [R_W-1:0] r5_reg [NC][3];
    logic signed [31:0]    c5_reg [3];
    logic signed [D_W-1:0] hsum;
    logic signed [D_W-1:0] lsum;

    always_comb
    begin
        hsum = '0;
        lsum = '0;
        for (int k = 0; k < NC; k++)
        begin
            hsum = D_W'(hp4_reg[k][0]) + D_W'(hp4_reg[k][1]) + D_W'(hp4_reg[k][2]);
            lsum = D_W'(lp4_reg[k][0]) + D_W'(lp4_reg[k][1]) + D_W'(lp4_reg[k][2]);
            dot_next[k] = (hsum <<< 16) + lsum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            dot5_reg <= dot_next;
            r5_reg   <= r4_reg;
            c5_reg   <= c4_reg;
        end
    end

    // ---------------- stages 6 to 8: compare tree ----------------
    // Lower index sits on the left; the right one wins only if strictly greater
    logic signed [D_W-1:0] dot6_reg [4];
    logic signed [R_W-1:0] r6_reg [4][3];
    logic [2:0]            idx6_reg [4];
    logic signed [31:0]    c6_reg [3];
    logic signed [D_W-1:0] dot7_reg [2];
    logic signed [R_W-1:0] r7_reg [2][3];
    logic [2:0]            idx7_reg [2];
    logic signed [31:0]    c7_reg [3];
    logic signed [R_W-1:0] r8_reg [3];
    logic [2:0]            idx8_reg;
    logic signed [31:0]    c8_reg [3];
    logic                  take6 [4];
    logic                  take7 [2];
    logic                  take8;

    always_comb
    begin
        for (int n = 0; n < 4; n++)
        begin
            take6[n] = dot5_reg[2*n+1] > dot5_reg[2*n];
        end
        for (int n = 0; n < 2; n++)
        begin
            take7[n] = dot6_reg[2*n+1] > dot6_reg[2*n];
        end
        take8 = dot7_reg[1] > dot7_reg[0];
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            for (int n = 0; n < 4; n++)
            begin
                dot6_reg[n] <= take6[n] ? dot5_reg[2*n+1] : dot5_reg[2*n];
                r6_reg[n]   <= take6[n] ? r5_reg[2*n+1] : r5_reg[2*n];
                idx6_reg[n] <= 3'(take6[n] ? 2*n+1 : 2*n);
            end
            c6_reg <= c5_reg;
        end
        if (en[7])
        begin
            for (int n = 0; n < 2; n++)
            begin
                dot7_reg[n] <= take7[n] ? dot6_reg[2*n+1] : dot6_reg[2*n];
                r7_reg[n]   <= take7[n] ? r6_reg[2*n+1] : r6_reg[2*n];
                idx7_reg[n] <= take7[n] ? idx6_reg[2*n+1] : idx6_reg[2*n];
            end
            c7_reg <= c6_reg;
        end
        if (en[8])
        begin
            r8_reg   <= take8 ? r7_reg[1] : r7_reg[0];
            idx8_reg <= take8 ? idx7_reg[1] : idx7_reg[0];
            c8_reg   <= c7_reg;
        end
    end

    // ---------------- stage 9: add centre, saturate ----------------
    logic signed [R_W:0]  psum [3];
    logic signed [31:0]   pt_next [3];
    obbsp_pkg::out_t      out_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            psum[i] = (R_W+1)'(r8_reg[i]) + (R_W+1)'(c8_reg[i]);
            if (psum[i] > (R_W+1)'(64'sd2147483647))
            begin
                pt_next[i] = 32'sh7fff_ffff;
            end
            else if (psum[i] < -(R_W+1)'(64'sd2147483648))
            begin
                pt_next[i] = 32'sh8000_0000;
            end
            else
            begin
                pt_next[i] = 32'(psum[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NS])
        begin
            out_reg.point_x      <= pt_next[0];
            out_reg.point_y      <= pt_next[1];
            out_reg.point_z      <= pt_next[2];
            out_reg.corner_index <= idx8_reg;
        end
    end

    assign out_data = out_reg;

    // ---------------- assertions ----------------
    a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without output back-pressure");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[NS-1] && en[NS]) |=> out_valid)
        else $error("item lost on its way to the output");

    a_rise_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(v_reg[NS-1]))
        else $error("result appeared without an item behind it");

    a_zero_dir_first: assert property (@(posedge clk) disable iff (!rst_n)
        (en[6] && v_reg[5] && dot5_reg[0] == dot5_reg[1]) |=> idx6_reg[0] == 3'd0)
        else $error("tie did not keep the lower corner");

endmodule

// ----- rtl/obbsp_matrix.sv -----
// ----------------------------------------------------------------------------
// obbsp_matrix
// Forms the rotation matrix of the configured quaternion, rounded to Q.16.
// ----------------------------------------------------------------------------
module obbsp_matrix (
    input  logic                              clk,
    input  obbsp_pkg::quat_t                  quat,
    output logic signed [obbsp_pkg::M_W-1:0]  mat [9]
);

    localparam int N_W = 35;
    localparam logic signed [N_W-1:0] ONE = N_W'(64'sd1 <<< 28);
    localparam logic signed [N_W-1:0] HALF_LSB = N_W'(64'sd1 <<< 11);

    logic signed [31:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
    logic signed [N_W-1:0] num [9];
    logic signed [obbsp_pkg::M_W-1:0] mat_next [9];
    logic signed [obbsp_pkg::M_W-1:0] mat_reg [9];

    always_comb
    begin
        xx = quat.x * quat.x;
        yy = quat.y * quat.y;
        zz = quat.z * quat.z;
        xy = quat.x * quat.y;
        xz = quat.x * quat.z;
        yz = quat.y * quat.z;
        wx = quat.w * quat.x;
        wy = quat.w * quat.y;
        wz = quat.w * quat.z;
        num[0] = ONE - 2 * (N_W'(yy) + N_W'(zz));
        num[1] = 2 * (N_W'(xy) - N_W'(wz));
        num[2] = 2 * (N_W'(xz) + N_W'(wy));
        num[3] = 2 * (N_W'(xy) + N_W'(wz));
        num[4] = ONE - 2 * (N_W'(xx) + N_W'(zz));
        num[5] = 2 * (N_W'(yz) - N_W'(wx));
        num[6] = 2 * (N_W'(xz) - N_W'(wy));
        num[7] = 2 * (N_W'(yz) + N_W'(wx));
        num[8] = ONE - 2 * (N_W'(xx) + N_W'(yy));
        for (int i = 0; i < 9; i++)
        begin
            mat_next[i] = obbsp_pkg::M_W'((num[i] + HALF_LSB) >>> 12);
        end
    end

    // Loads every cycle; user must change config only while idle, unchecked
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 9; i++)
        begin
            mat_reg[i] <= mat_next[i];
        end
    end

    assign mat = mat_reg;

endmodule

// ----- test/tb_obb_support_point.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_obb_support_point
// Self-checking bench for the box support point block.
// ----------------------------------------------------------------------------
// Writes orientation and half-extents over APB between phases, sends a table
// of directed queries and then random ones, and checks every output item with
// a hand-typed result or a behavioral support function. Both channels idle at
// random; one phase stalls the receiver long enough to fill the pipe.
// ----------------------------------------------------------------------------
module tb_obb_support_point;

    localparam int  MAX_CYCLES = 400000;
    localparam int  LATENCY    = 9;

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_ready;
    obbsp_pkg::in_t  in_data;
    logic            out_valid;
    logic            out_ready;
    obbsp_pkg::out_t out_data;
    logic            psel;
    logic            penable;
    logic            pwrite;
    logic [4:0]      paddr;
    logic [31:0]     pwdata;
    logic [31:0]     prdata;
    logic            pready;

    obb_support_point dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // bench copy of the configuration
    logic signed [15:0] qw, qx, qy, qz;
    logic [29:0]        hx, hy, hz;

    obbsp_pkg::out_t expected_points[$];
    int     mismatches;
    int     points_checked;
    int     queries_sent;
    longint cycles;
    int     in_idle_pct;
    int     out_idle_pct;
    bit     hold_off_req;
    bit     hold_off_busy;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d items pending", cycles,
                     expected_points.size());
            $display("FAIL obb_support_point");
            $finish;
        end
    end

    function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // farthest corner along the direction, rotated then moved to the centre
    function automatic obbsp_pkg::out_t support_point(obbsp_pkg::in_t q);
        logic signed [127:0] m [3][3];
        logic signed [127:0] e [3];
        logic signed [127:0] d [3];
        logic signed [127:0] r [3];
        logic signed [127:0] best_r [3];
        logic signed [127:0] s, dot, best_dot;
        logic signed [127:0] w, x, y, z, one;
        logic [2:0]          best;
        logic [7:0]          sx, sy, sz;
        obbsp_pkg::out_t     res;
        w = qw; x = qx; y = qy; z = qz;
        one = 128'sd1 <<< 28;
        m[0][0] = one - 2 * (y*y + z*z);
        m[0][1] = 2 * (x*y - w*z);
        m[0][2] = 2 * (x*z + w*y);
        m[1][0] = 2 * (x*y + w*z);
        m[1][1] = one - 2 * (x*x + z*z);
        m[1][2] = 2 * (y*z - w*x);
        m[2][0] = 2 * (x*z - w*y);
        m[2][1] = 2 * (y*z + w*x);
        m[2][2] = one - 2 * (x*x + y*y);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = (m[i][j] + (128'sd1 <<< 11)) >>> 12;
        e[0] = $signed({98'd0, hx}) + 1;
        e[1] = $signed({98'd0, hy}) + 1;
        e[2] = $signed({98'd0, hz}) + 1;
        d[0] = q.dir_x; d[1] = q.dir_y; d[2] = q.dir_z;
        sx = obbsp_pkg::SGN_X; sy = obbsp_pkg::SGN_Y; sz = obbsp_pkg::SGN_Z;
        best = '0;
        best_dot = '0;
        for (int k = 0; k < obbsp_pkg::NUM_CORNERS; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s = (sx[k] ? m[i][0] : -m[i][0]) * e[0]
                  + (sy[k] ? m[i][1] : -m[i][1]) * e[1]
                  + (sz[k] ? m[i][2] : -m[i][2]) * e[2];
                r[i] = (s + (128'sd1 <<< 15)) >>> 16;
            end
            dot = r[0] * d[0] + r[1] * d[1] + r[2] * d[2];
            if (k == 0 || dot > best_dot)
            begin
                best = 3'(k);
                best_dot = dot;
                best_r = r;
            end
        end
        res.point_x = clamp32(64'(best_r[0] + $signed(q.centre_x)));
        res.point_y = clamp32(64'(best_r[1] + $signed(q.centre_y)));
        res.point_z = clamp32(64'(best_r[2] + $signed(q.centre_z)));
        res.corner_index = best;
        return res;
    endfunction

    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            obbsp_pkg::REG_QUAT_W: qw = val[15:0];
            obbsp_pkg::REG_QUAT_X: qx = val[15:0];
            obbsp_pkg::REG_QUAT_Y: qy = val[15:0];
            obbsp_pkg::REG_QUAT_Z: qz = val[15:0];
            obbsp_pkg::REG_HALF_X: hx = val[29:0];
            obbsp_pkg::REG_HALF_Y: hy = val[29:0];
            obbsp_pkg::REG_HALF_Z: hz = val[29:0];
            default: ;
        endcase
    endtask

    task automatic load_box(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                            logic [15:0] z, logic [29:0] ex, logic [29:0] ey,
                            logic [29:0] ez);
        apb_write(obbsp_pkg::REG_QUAT_W, {16'd0, w});
        apb_write(obbsp_pkg::REG_QUAT_X, {16'd0, x});
        apb_write(obbsp_pkg::REG_QUAT_Y, {16'd0, y});
        apb_write(obbsp_pkg::REG_QUAT_Z, {16'd0, z});
        apb_write(obbsp_pkg::REG_HALF_X, {2'd0, ex});
        apb_write(obbsp_pkg::REG_HALF_Y, {2'd0, ey});
        apb_write(obbsp_pkg::REG_HALF_Z, {2'd0, ez});
        // let the matrix follow the last write
        repeat (2) @(negedge clk);
    endtask

    // send one query; optionally store a hand-typed expectation
    task automatic send_query(obbsp_pkg::in_t q, bit use_fixed,
                              obbsp_pkg::out_t fixed_res);
        while (($urandom_range(99) < in_idle_pct))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= q;
        if (use_fixed)
            expected_points.push_back(fixed_res);
        else
            expected_points.push_back(support_point(q));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        queries_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_points.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 2) @(negedge clk);
    endtask

    function automatic logic [31:0] random_word();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'(signed'($urandom_range(131072)) - 65536);
            default: return $urandom;
        endcase
    endfunction

    function automatic obbsp_pkg::in_t random_query(int span);
        obbsp_pkg::in_t q;
        q.dir_x = random_word();
        q.dir_y = random_word();
        q.dir_z = random_word();
        if (span == 0)
        begin
            q.centre_x = $urandom;
            q.centre_y = $urandom;
            q.centre_z = $urandom;
        end
        else
        begin
            q.centre_x = 32'(signed'($urandom_range(2*span)) - span);
            q.centre_y = 32'(signed'($urandom_range(2*span)) - span);
            q.centre_z = 32'(signed'($urandom_range(2*span)) - span);
        end
        if ($urandom_range(15) == 0)
            q.dir_x = 0;
        return q;
    endfunction

    // output side: random stall plus an optional long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off_busy)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    initial
    begin
        hold_off_busy = 1'b0;
        wait (hold_off_req);
        hold_off_busy = 1'b1;
        repeat (60) @(posedge clk);
        hold_off_busy = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_points.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item %h", out_data);
            end
            else
            begin
                obbsp_pkg::out_t want;
                want = expected_points.pop_front();
                points_checked++;
                if (out_data.point_x !== want.point_x ||
                    out_data.point_y !== want.point_y ||
                    out_data.point_z !== want.point_z ||
                    out_data.corner_index !== want.corner_index)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h %h %h c%0d got %h %h %h c%0d",
                                 want.point_x, want.point_y, want.point_z,
                                 want.corner_index, out_data.point_x,
                                 out_data.point_y, out_data.point_z,
                                 out_data.corner_index);
                end
            end
        end
    end

    typedef struct {
        obbsp_pkg::in_t  q;
        bit              fixed;
        obbsp_pkg::out_t res;
    } query_row_t;

    query_row_t directed_rows[$];

    function automatic obbsp_pkg::in_t mk(logic [31:0] dx, logic [31:0] dy,
                                          logic [31:0] dz, logic [31:0] cx,
                                          logic [31:0] cy, logic [31:0] cz);
        obbsp_pkg::in_t q;
        q.dir_x = dx; q.dir_y = dy; q.dir_z = dz;
        q.centre_x = cx; q.centre_y = cy; q.centre_z = cz;
        return q;
    endfunction

    function automatic obbsp_pkg::out_t pt(logic [31:0] x, logic [31:0] y,
                                           logic [31:0] z, logic [2:0] c);
        obbsp_pkg::out_t r;
        r.point_x = x; r.point_y = y; r.point_z = z; r.corner_index = c;
        return r;
    endfunction

    initial
    begin
        query_row_t     row;
        obbsp_pkg::in_t q;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        cycles = 0;
        mismatches = 0; points_checked = 0; queries_sent = 0;
        in_idle_pct = 34; out_idle_pct = 34;
        hold_off_req = 1'b0;
        qw = 16384; qx = 0; qy = 0; qz = 0;
        hx = 32768; hy = 32768; hz = 32768;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // after reset: unit quaternion, half-extents 0.5 + 1 LSB = 32769
        directed_rows.push_back('{mk(0, 0, 0, 0, 0, 0), 1,
                                  pt(32769, -32769, -32769, 0)});
        directed_rows.push_back('{mk(1, 1, 1, 0, 0, 0), 1,
                                  pt(32769, 32769, 32769, 5)});
        directed_rows.push_back('{mk(-1, -1, -1, 0, 0, 0), 1,
                                  pt(-32769, -32769, -32769, 3)});
        directed_rows.push_back('{mk(-1, 1, -1, 100, 200, 300), 1,
                                  pt(-32669, 32969, -32469, 2)});
        directed_rows.push_back('{mk(1, -1, 1, 0, 0, 0), 1,
                                  pt(32769, -32769, 32769, 4)});
        directed_rows.push_back('{mk(-1, 1, 1, 0, 0, 0), 1,
                                  pt(-32769, 32769, 32769, 6)});
        directed_rows.push_back('{mk(-1, -1, 1, 0, 0, 0), 1,
                                  pt(-32769, -32769, 32769, 7)});
        directed_rows.push_back('{mk(1, 1, -1, 0, 0, 0), 1,
                                  pt(32769, 32769, -32769, 1)});
        // saturation at both ends
        directed_rows.push_back('{mk(1, 1, 1, 32'h7fffffff, 32'h7fffffff,
                                     32'h7fffffff), 1,
                                  pt(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 5)});
        directed_rows.push_back('{mk(-1, -1, -1, 32'h80000000, 32'h80000000,
                                     32'h80000000), 1,
                                  pt(32'h80000000, 32'h80000000, 32'h80000000, 3)});
        // direction extremes and ties on one axis
        directed_rows.push_back('{mk(32'h7fffffff, 0, 0, 0, 0, 0), 0, '0});
        directed_rows.push_back('{mk(32'h80000000, 32'h80000000, 32'h80000000,
                                     0, 0, 0), 0, '0});
        directed_rows.push_back('{mk(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                                     32'hffffffff, 1, 32'h55555555), 0, '0});
        directed_rows.push_back('{mk(0, 32'hffffffff, 0, 32'haaaaaaaa,
                                     32'h55555555, 0), 0, '0});

        foreach (directed_rows[i])
            send_query(directed_rows[i].q, directed_rows[i].fixed,
                       directed_rows[i].res);
        drain();

        // extreme configurations, a few directed queries each
        load_box(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                 30'h3fffffff, 30'h3fffffff, 30'h3fffffff);
        send_query(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0), 0, '0);
        send_query(mk(32'h80000000, 1, 0, 32'h80000000, 0, 32'h7fffffff), 0, '0);
        send_query(mk(0, 0, 0, 0, 0, 0), 0, '0);
        drain();
        load_box(16'h8000, 16'h8000, 16'h8000, 16'h8000, 30'd0, 30'd0, 30'd0);
        send_query(mk(1, -1, 1, 5, 6, 7), 0, '0);
        send_query(mk(32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0, 0), 0, '0);
        drain();

        // random phases, each with its own box
        for (int phase = 0; phase < 7; phase++)
        begin
            if (phase == 2)
            begin
                in_idle_pct = 0;
                out_idle_pct = 0;
            end
            else
            begin
                in_idle_pct = 34;
                out_idle_pct = 34;
            end
            load_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     (phase % 3 == 0) ? 30'($urandom) : 30'($urandom_range(1 << 20)),
                     (phase % 3 == 0) ? 30'($urandom) : 30'($urandom_range(1 << 20)),
                     (phase % 3 == 0) ? 30'($urandom) : 30'($urandom_range(1 << 20)));
            for (int n = 0; n < 150; n++)
            begin
                if (phase == 4 && n == 10)
                    hold_off_req = 1'b1;
                q = random_query((n % 2) ? 0 : (1 << 24));
                send_query(q, 0, '0);
            end
            hold_off_req = 1'b0;
            drain();
        end

        $display("covered %0d queries, %0d items checked over 10 box settings",
                 queries_sent, points_checked);
        $display("with random stalls, a long output hold-off and saturating centres");
        if (mismatches == 0)
            $display("PASS obb_support_point");
        else
            $display("FAIL obb_support_point");
        $finish;
    end

endmodule
